// File: sv/csvfp_pkg.sv
// Shared types, constants and helpers for the CSV field parser.
package csvfp_pkg;

    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SEP28   = 8'd28;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2C;

    typedef enum logic [2:0] {
        PH_START,
        PH_PLAIN,
        PH_QUOTED,
        PH_QPEND,
        PH_SEP28,
        PH_AFTER_NL
    } phase_t;

    typedef struct packed {
        logic             kind;          // 0 content byte, 1 field descriptor
        logic [7:0]       content_byte;
        logic [CNT_W-1:0] content_offset;
        logic             start_offset;
        logic [CNT_W-1:0] field_length;
        logic [CNT_W-1:0] quote_count;
        logic [CNT_W-1:0] comma_count;
        logic [CNT_W-1:0] field_index;
        logic             line_last;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_sub2(input logic [CNT_W-1:0] v);
        return (v >= CNT_W'(2)) ? v - CNT_W'(2) : '0;
    endfunction

endpackage

// File: sv/csvfp_core.sv
// Parser state and per-byte step logic; produces at most one result per byte.
module csvfp_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,        // accept one byte this cycle
    input  logic [7:0]        byte_value,
    input  logic              sep28_mode,
    output logic              has_result,
    output csvfp_pkg::result_t result
);
    import csvfp_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] quotes_reg, quotes_next;
    logic [CNT_W-1:0] commas_reg, commas_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       last_reg, last_next;
    logic [CNT_W-1:0] field_reg, field_next;

    logic             clear;
    logic             do_content;
    logic             do_desc;
    phase_t           content_phase;
    logic [CNT_W-1:0] cnt_e, quotes_e, commas_e;
    logic [7:0]       first_e, last_e;
    logic             end_csv, end_sep, strip, line_end;

    assign end_csv = (byte_value == CH_NUL) || (byte_value == CH_COMMA)
                   || (byte_value == CH_NEWLINE);
    assign end_sep = (byte_value == CH_NUL) || (byte_value == CH_SEP28)
                   || (byte_value == CH_NEWLINE);

    // classify the byte against the current phase
    always_comb
    begin
        clear         = 1'b0;
        do_content    = 1'b0;
        do_desc       = 1'b0;
        content_phase = phase_reg;
        unique case (phase_reg) inside
            PH_PLAIN:
            begin
                if (end_csv) do_desc = 1'b1;
                else         do_content = 1'b1;
            end
            PH_SEP28:
            begin
                if (end_sep) do_desc = 1'b1;
                else         do_content = 1'b1;
            end
            PH_QUOTED:
            begin
                if (byte_value == CH_NUL)        do_desc = 1'b1;
                else if (byte_value == CH_QUOTE) content_phase = PH_QPEND;
                else                             do_content = 1'b1;
            end
            PH_QPEND:
            begin
                if (byte_value == CH_QUOTE)
                begin
                    content_phase = PH_QUOTED;
                    do_content    = 1'b1;
                end
                else
                begin
                    do_desc = 1'b1;
                end
            end
            PH_AFTER_NL, PH_START:
            begin
                if (phase_reg == PH_AFTER_NL && byte_value == CH_NUL)
                begin
                    content_phase = PH_START;  // zero right after a newline
                end
                else
                begin
                    clear = 1'b1;
                    if (sep28_mode)
                    begin
                        if (end_sep) do_desc = 1'b1;
                        else
                        begin
                            content_phase = PH_SEP28;
                            do_content    = 1'b1;
                        end
                    end
                    else if (byte_value == CH_QUOTE)
                    begin
                        content_phase = PH_QUOTED;
                    end
                    else if (end_csv)
                    begin
                        do_desc = 1'b1;
                    end
                    else
                    begin
                        content_phase = PH_PLAIN;
                        do_content    = 1'b1;
                    end
                end
            end
            default:
            begin
                content_phase = PH_START;
            end
        endcase
    end

    assign cnt_e    = clear ? '0 : cnt_reg;
    assign quotes_e = clear ? '0 : quotes_reg;
    assign commas_e = clear ? '0 : commas_reg;
    assign first_e  = clear ? 8'h00 : first_reg;
    assign last_e   = clear ? 8'h00 : last_reg;

    assign strip    = (cnt_e > CNT_W'(1)) && (first_e == CH_QUOTE) && (last_e == CH_QUOTE);
    assign line_end = (byte_value == CH_NUL) || (byte_value == CH_NEWLINE);

    always_comb
    begin
        phase_next  = content_phase;
        cnt_next    = cnt_e;
        quotes_next = quotes_e;
        commas_next = commas_e;
        first_next  = first_e;
        last_next   = last_e;
        field_next  = field_reg;
        has_result  = do_content || do_desc;
        result      = '0;
        if (do_content)
        begin
            result.kind           = 1'b0;
            result.content_byte   = byte_value;
            result.content_offset = cnt_e;
            if (cnt_e == '0) first_next = byte_value;
            last_next = byte_value;
            cnt_next  = sat_inc(cnt_e);
            if (byte_value == CH_QUOTE)      quotes_next = sat_inc(quotes_e);
            else if (byte_value == CH_COMMA) commas_next = sat_inc(commas_e);
        end
        else if (do_desc)
        begin
            result.kind         = 1'b1;
            result.start_offset = strip;
            result.field_length = strip ? sat_sub2(cnt_e) : cnt_e;
            result.quote_count  = strip ? sat_sub2(quotes_e) : quotes_e;
            result.comma_count  = commas_e;
            result.field_index  = field_reg;
            result.line_last    = line_end;
            field_next = line_end ? '0 : sat_inc(field_reg);
            phase_next = (byte_value == CH_NEWLINE) ? PH_AFTER_NL : PH_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            cnt_reg    <= '0;
            quotes_reg <= '0;
            commas_reg <= '0;
            first_reg  <= 8'h00;
            last_reg   <= 8'h00;
            field_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            quotes_reg <= quotes_next;
            commas_reg <= commas_next;
            first_reg  <= first_next;
            last_reg   <= last_next;
            field_reg  <= field_next;
        end
    end

endmodule

// File: sv/csv_field_parser_unit.sv
// Top level of the CSV field parser: stream ports, mode register, output buffer.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | tdata: byte_value
//  m_*      | out       | tdata: result fields, tuser: kind, tlast: line_last
//  cfg_*    | in        | separator28_mode, write only
//
// One byte per cycle while s_tready is high; each byte is parsed in the cycle
// it is accepted and its result goes to a two-entry output buffer, reaching
// m_* behind any earlier results. s_tready drops only when both entries are
// full, so one waiting result does not stall input. Reset clears parser state,
// the buffer and the mode register (comma mode); no clearing pass is needed.
module csv_field_parser_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [7:0] content_byte, [23:8] content_offset,
                                   // [24] start_offset, [40:25] field_length,
                                   // [56:41] quote_count, [72:57] comma_count,
                                   // [88:73] field_index, [95:89] zero
    output logic        m_tuser,   // kind
    output logic        m_tlast,   // line_last
    input  logic        cfg_we,
    input  logic        cfg_wdata  // separator28_mode
);
    import csvfp_pkg::*;

    logic    mode_reg;
    logic    step;
    logic    has_result;
    logic    push;
    logic    pop;
    result_t new_res;
    result_t head_reg;
    result_t skid_reg;
    logic    head_v_reg;
    logic    skid_v_reg;

    assign s_tready = !skid_v_reg;
    assign step     = s_tvalid && s_tready;
    assign push     = step && has_result;
    assign pop      = head_v_reg && m_tready;

    csvfp_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_value (s_tdata),
        .sep28_mode (mode_reg),
        .has_result (has_result),
        .result     (new_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // two-entry output buffer; the skid entry only fills while the head is occupied
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (pop || !head_v_reg)
        begin
            if (skid_v_reg)
            begin
                head_v_reg <= 1'b1;
                skid_v_reg <= push;
            end
            else
            begin
                head_v_reg <= push;
            end
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !head_v_reg)
        begin
            if (skid_v_reg)
            begin
                head_reg <= skid_reg;
                if (push) skid_reg <= new_res;
            end
            else if (push)
            begin
                head_reg <= new_res;
            end
        end
        else if (push)
        begin
            skid_reg <= new_res;
        end
    end

    assign m_tvalid = head_v_reg;
    assign m_tuser  = head_reg.kind;
    assign m_tlast  = head_reg.line_last;
    assign m_tdata  = {7'b0,
                       head_reg.field_index,
                       head_reg.comma_count,
                       head_reg.quote_count,
                       head_reg.field_length,
                       head_reg.start_offset,
                       head_reg.content_offset,
                       head_reg.content_byte};

endmodule
